// ----- sv/h264fu_pkg.sv -----
// ----------------------------------------------------------------------------
// H.264 FU-A packetizer package
// Shared widths, constants and the result buffer entry type.
// ----------------------------------------------------------------------------
package h264fu_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LIMIT_W  = 11;
    localparam int unsigned LENGTH_W = 24;

    // FU indicator type code and limits on the payload register
    localparam logic [4:0]         FU_A_TYPE       = 5'd28;
    localparam logic [LIMIT_W-1:0] PAYLOAD_CEILING = 11'd1498;
    localparam logic [LIMIT_W-1:0] PAYLOAD_RESET   = 11'd1380;

    // One registered input byte with everything needed to emit its results
    typedef struct packed {
        logic              hdr;      // FU indicator and FU header go first
        logic [BYTE_W-1:0] ind;      // FU indicator byte
        logic [BYTE_W-1:0] fuh;      // FU header byte
        logic [BYTE_W-1:0] data;     // the NAL byte itself
        logic              start;    // packet start flag on the data byte
        logic              stop;     // packet end flag on the data byte
        logic              marker;   // RTP marker for the whole packet
    } result_entry_t;

endpackage

// ----- sv/h264_rtp_fu_a_packetizer_top.sv -----
// ----------------------------------------------------------------------------
// H.264 RTP FU-A packetizer
// Turns a stream of NAL unit bytes into RTP payload bytes, either as single
// NAL unit packets or as FU-A fragments that each carry at most the clamped max_payload NAL bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one NAL byte per request; the
//   header byte carries first_of_unit and the unit's total length.
//   Output channel (out_valid / out_stall) gives one payload byte per request
//   with packet_start, packet_end, rtp_marker and run_last.
//   max_payload is written through max_payload_we while the block is idle and
//   takes effect at the next header byte; values are clamped to 1..1498.
//   A result is registered and appears in the cycle after its byte is taken.
//   Throughput: one byte per cycle while in_stall is low. A byte that opens a
//   fragment yields three results (FU indicator, FU header, byte) and holds the
//   input until the last of them is taken; the header of a fragmented unit yields
//   none. The result register drains while the next byte is taken in the same cycle.
//   Receiver stall: the result register holds and in_stall rises until the
//   last result of the buffered byte is taken.
//   Reset: no unit open, result register empty, limit back to 1380.
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_packetizer_top
    import h264fu_pkg::*;
#(
    parameter int unsigned MAX_UNIT_BYTES = 8388608
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                max_payload_we,
    input  logic [LIMIT_W-1:0]  max_payload,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   nal_byte,
    input  logic                first_of_unit,
    input  logic [LENGTH_W-1:0] unit_length,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                packet_start,
    output logic                packet_end,
    output logic                rtp_marker,
    output logic                run_last
);

    localparam int unsigned REM_W = $clog2(MAX_UNIT_BYTES);
    localparam int unsigned CMP_W = (REM_W > LIMIT_W) ? REM_W : LIMIT_W;
    localparam logic [LENGTH_W:0] LEN_CAP = (LENGTH_W + 1)'(MAX_UNIT_BYTES);

    // configuration and unit state
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIMIT_W-1:0]  unit_payload_reg, unit_payload_next;
    logic [REM_W-1:0]    remaining_reg, remaining_next;
    logic [LIMIT_W-1:0]  chunk_room_reg, chunk_room_next;
    logic [BYTE_W-1:0]   header_reg, header_next;
    logic                frag_reg, frag_next;
    logic                first_frag_reg, first_frag_next;

    // result buffer
    result_entry_t       entry_reg, entry_next;
    logic                buf_valid_reg, buf_valid_next;
    logic [1:0]          buf_pos_reg, buf_pos_next;

    // handshake
    logic                out_take;
    logic                last_entry;
    logic                in_take;

    // header decode
    logic [LIMIT_W-1:0]  limit_clamped;
    logic [LENGTH_W-1:0] len_nonzero;
    logic [LENGTH_W-1:0] len_clamped;
    logic [LENGTH_W-1:0] len_minus1;
    logic                len_is_frag;

    // payload byte decode
    logic                chunk_final;
    logic                chunk_end;
    logic                chunk_head;
    logic                byte_last;
    logic                produce;

    // ------------------------------------------------------------------
    // Handshake: drain the buffer while taking the next byte
    // ------------------------------------------------------------------
    assign out_valid  = buf_valid_reg;
    assign last_entry = !entry_reg.hdr || (buf_pos_reg == 2'd2);
    assign out_take   = buf_valid_reg && !out_stall;
    assign in_stall   = buf_valid_reg && !(out_take && last_entry);
    assign in_take    = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Select the result at the current buffer position
    // ------------------------------------------------------------------
    always_comb
    begin
        out_byte     = entry_reg.data;
        packet_start = entry_reg.start;
        packet_end   = entry_reg.stop;
        rtp_marker   = entry_reg.marker;
        run_last     = last_entry;
        if (entry_reg.hdr)
        begin
            case (buf_pos_reg)
                2'd0:
                begin
                    out_byte     = entry_reg.ind;
                    packet_start = 1'b1;
                    packet_end   = 1'b0;
                end
                2'd1:
                begin
                    out_byte     = entry_reg.fuh;
                    packet_start = 1'b0;
                    packet_end   = 1'b0;
                end
                default:
                begin
                    out_byte     = entry_reg.data;
                    packet_start = 1'b0;
                    packet_end   = entry_reg.stop;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decode a header byte: clamp limit and length, pick the mode
    // ------------------------------------------------------------------
    always_comb
    begin
        limit_clamped = limit_reg;
        if (limit_reg == '0)
        begin
            limit_clamped = LIMIT_W'(1);
        end
        else if (limit_reg > PAYLOAD_CEILING)
        begin
            limit_clamped = PAYLOAD_CEILING;
        end

        len_nonzero = (unit_length == '0) ? LENGTH_W'(1) : unit_length;
        if ((LENGTH_W + 1)'(len_nonzero) > LEN_CAP)
        begin
            len_clamped = LEN_CAP[LENGTH_W-1:0];
        end
        else
        begin
            len_clamped = len_nonzero;
        end
        len_minus1  = len_clamped - LENGTH_W'(1);
        len_is_frag = len_clamped > LENGTH_W'(limit_clamped);
    end

    // ------------------------------------------------------------------
    // Decode a payload byte of an open unit
    // ------------------------------------------------------------------
    assign byte_last   = (remaining_reg == REM_W'(1));
    assign chunk_final = CMP_W'(remaining_reg) <= CMP_W'(chunk_room_reg);
    assign chunk_end   = byte_last || (chunk_room_reg <= LIMIT_W'(1));
    assign chunk_head  = (chunk_room_reg == unit_payload_reg);

    // ------------------------------------------------------------------
    // Advance unit state and load the result buffer
    // ------------------------------------------------------------------
    always_comb
    begin
        unit_payload_next = unit_payload_reg;
        remaining_next    = remaining_reg;
        chunk_room_next   = chunk_room_reg;
        header_next       = header_reg;
        frag_next         = frag_reg;
        first_frag_next   = first_frag_reg;
        entry_next        = entry_reg;
        produce           = 1'b0;

        if (first_of_unit)
        begin
            unit_payload_next = limit_clamped;
            remaining_next    = REM_W'(len_minus1);
            chunk_room_next   = limit_clamped;
            header_next       = nal_byte;
            frag_next         = len_is_frag;
            first_frag_next   = 1'b1;
            produce           = !len_is_frag;
            entry_next.hdr    = 1'b0;
            entry_next.data   = nal_byte;
            entry_next.start  = 1'b1;
            entry_next.stop   = (len_minus1 == '0);
            entry_next.marker = 1'b1;
        end
        else if (remaining_reg != '0)
        begin
            remaining_next    = remaining_reg - REM_W'(1);
            produce           = 1'b1;
            entry_next.data   = nal_byte;
            entry_next.start  = 1'b0;
            if (!frag_reg)
            begin
                entry_next.hdr    = 1'b0;
                entry_next.stop   = byte_last;
                entry_next.marker = 1'b1;
            end
            else
            begin
                entry_next.hdr    = chunk_head;
                entry_next.ind    = {header_reg[7:5], FU_A_TYPE};
                entry_next.fuh    = {first_frag_reg, chunk_final, 1'b0, header_reg[4:0]};
                entry_next.stop   = chunk_end;
                entry_next.marker = chunk_final;
                first_frag_next   = 1'b0;
                chunk_room_next   = chunk_end ? unit_payload_reg
                                              : chunk_room_reg - LIMIT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Buffer control: load on a taken byte, step through its results
    // ------------------------------------------------------------------
    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        buf_pos_next   = buf_pos_reg;
        if (out_take)
        begin
            if (last_entry)
            begin
                buf_valid_next = 1'b0;
            end
            else
            begin
                buf_pos_next = buf_pos_reg + 2'd1;
            end
        end
        if (in_take)
        begin
            buf_valid_next = produce;
            buf_pos_next   = 2'd0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg        <= PAYLOAD_RESET;
            unit_payload_reg <= '0;
            remaining_reg    <= '0;
            chunk_room_reg   <= '0;
            header_reg       <= '0;
            frag_reg         <= 1'b0;
            first_frag_reg   <= 1'b0;
            buf_valid_reg    <= 1'b0;
            buf_pos_reg      <= 2'd0;
        end
        else
        begin
            if (max_payload_we)
            begin
                limit_reg <= max_payload;
            end
            if (in_take)
            begin
                unit_payload_reg <= unit_payload_next;
                remaining_reg    <= remaining_next;
                chunk_room_reg   <= chunk_room_next;
                header_reg       <= header_next;
                frag_reg         <= frag_next;
                first_frag_reg   <= first_frag_next;
            end
            buf_valid_reg <= buf_valid_next;
            buf_pos_reg   <= buf_pos_next;
        end
    end

    // hold payload of the buffer, load it with each taken byte
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            entry_reg <= entry_next;
        end
    end

`ifndef SYNTHESIS
    // a stalled input always has a result waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result buffer");

    // the FU indicator is followed by a result that opens no packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && entry_reg.hdr && buf_pos_reg == 2'd0) |=>
            (out_valid && !packet_start && !run_last))
        else $error("FU indicator not followed by FU header");

    // an open fragmented unit keeps chunk room within 1..limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (frag_reg && remaining_reg != '0) |->
            (chunk_room_reg != '0 && chunk_room_reg <= unit_payload_reg
             && unit_payload_reg <= PAYLOAD_CEILING))
        else $error("chunk room out of range");
`endif

endmodule

// ----- dv/fu_a_payload_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FU-A payload checker
// Watches the request and result channels of the H.264 RTP packetizer. It
// predicts the payload bytes that each NAL byte should produce, including
// single NAL unit packets and FU-A fragments, and compares every result
// byte with the oldest prediction.
// ----------------------------------------------------------------------------
module fu_a_payload_checker
    import h264fu_pkg::*;
#(
    parameter int unsigned MAX_UNIT_BYTES = 8388608
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_limit,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [BYTE_W-1:0]   nal_byte,
    input  logic                first_of_unit,
    input  logic [LENGTH_W-1:0] unit_length,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [BYTE_W-1:0]   out_byte,
    input  logic                packet_start,
    input  logic                packet_end,
    input  logic                rtp_marker,
    input  logic                run_last,
    output int                  mismatch_count,
    output int                  pending_count,
    output int                  bytes_taken,
    output int                  payload_checked
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              stop;
        logic              marker;
        logic              last;
    } payload_byte_t;

    payload_byte_t expected_payload[$];

    // Shadow of the packetizer state
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIMIT_W-1:0]  unit_limit;
    logic [LENGTH_W-1:0] unit_len;
    logic [LENGTH_W-1:0] consumed;
    logic [BYTE_W-1:0]   nal_header;
    logic                fragmenting;
    logic [LIMIT_W-1:0]  chunk_fill;

    int mismatches;
    int taken_count;
    int checked_count;

    function automatic void push_result(input logic [BYTE_W-1:0] data,
                                        input logic start, input logic stop,
                                        input logic marker, input logic last);
        payload_byte_t entry;
        entry.data   = data;
        entry.start  = start;
        entry.stop   = stop;
        entry.marker = marker;
        entry.last   = last;
        expected_payload.push_back(entry);
    endfunction

    // Predict the payload bytes caused by one NAL byte
    task automatic packetize_byte(input logic [BYTE_W-1:0] b, input logic first,
                                  input logic [LENGTH_W-1:0] len_in);
        logic [LIMIT_W-1:0]  lim;
        logic [LENGTH_W-1:0] len;
        logic [LENGTH_W-1:0] off;
        logic [LENGTH_W-1:0] chunk_base;
        logic                last_chunk;
        logic                chunk_end;
        if (first)
        begin
            // clamp the limit and the length, then open the unit
            lim = limit_reg;
            if (lim == '0)
                lim = LIMIT_W'(1);
            if (lim > PAYLOAD_CEILING)
                lim = PAYLOAD_CEILING;
            len = len_in;
            if (len == '0)
                len = LENGTH_W'(1);
            if (len > MAX_UNIT_BYTES)
                len = LENGTH_W'(MAX_UNIT_BYTES);
            unit_limit  = lim;
            unit_len    = len;
            nal_header  = b;
            fragmenting = (len > lim);
            consumed    = LENGTH_W'(1);
            chunk_fill  = '0;
            if (!fragmenting)
                push_result(b, 1'b1, len == 1, 1'b1, 1'b1);
        end
        else if (consumed < unit_len)
        begin
            off      = consumed;
            consumed = off + LENGTH_W'(1);
            if (!fragmenting)
            begin
                push_result(b, 1'b0, consumed == unit_len, 1'b1, 1'b1);
            end
            else
            begin
                chunk_base = off - chunk_fill;
                last_chunk = (unit_len - chunk_base) <= unit_limit;
                chunk_end  = (consumed == unit_len) || (chunk_fill + 1 >= unit_limit);
                // open a fragment with FU indicator and FU header
                if (chunk_fill == '0)
                begin
                    push_result({nal_header[7:5], FU_A_TYPE}, 1'b1, 1'b0,
                                last_chunk, 1'b0);
                    push_result({off == 1, last_chunk, 1'b0, nal_header[4:0]},
                                1'b0, 1'b0, last_chunk, 1'b0);
                end
                push_result(b, 1'b0, chunk_end, last_chunk, 1'b1);
                chunk_fill = chunk_end ? '0 : chunk_fill + LIMIT_W'(1);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        payload_byte_t got;
        payload_byte_t want;
        if (!rst_n)
        begin
            expected_payload.delete();
            limit_reg       = PAYLOAD_RESET;
            unit_limit      = '0;
            unit_len        = '0;
            consumed        = '0;
            nal_header      = '0;
            fragmenting     = 1'b0;
            chunk_fill      = '0;
            mismatches      = 0;
            taken_count     = 0;
            checked_count   = 0;
            mismatch_count  <= 0;
            pending_count   <= 0;
            bytes_taken     <= 0;
            payload_checked <= 0;
        end
        else
        begin
            // compare a taken result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.data   = out_byte;
                got.start  = packet_start;
                got.stop   = packet_end;
                got.marker = rtp_marker;
                got.last   = run_last;
                if (expected_payload.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"ERROR: unexpected payload byte %02h ",
                                  "start=%b end=%b marker=%b last=%b"},
                                 got.data, got.start, got.stop, got.marker, got.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_payload.pop_front();
                    if (got.data !== want.data || got.start !== want.start ||
                        got.stop !== want.stop || got.marker !== want.marker ||
                        got.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"ERROR: payload byte %0d: ",
                                      "expected %02h s=%b e=%b m=%b l=%b, ",
                                      "got %02h s=%b e=%b m=%b l=%b"},
                                     checked_count, want.data, want.start, want.stop,
                                     want.marker, want.last, got.data, got.start,
                                     got.stop, got.marker, got.last);
                        mismatches++;
                    end
                end
                checked_count++;
            end
            // a header taken at the write edge still sees the old limit
            if (in_valid && !in_stall)
            begin
                packetize_byte(nal_byte, first_of_unit, unit_length);
                taken_count++;
            end
            if (cfg_we)
                limit_reg = cfg_limit;
            mismatch_count  <= mismatches;
            pending_count   <= expected_payload.size();
            bytes_taken     <= taken_count;
            payload_checked <= checked_count;
        end
    end

endmodule

// ----- dv/h264_rtp_fu_a_packetizer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H.264 RTP FU-A packetizer testbench
// Drives NAL units through the packetizer under several payload limits, with
// bursty requests and a stalling receiver; a payload checker beside the block
// predicts and compares every result byte.
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_packetizer_top_tb
    import h264fu_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 260;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                max_payload_we = 1'b0;
    logic [LIMIT_W-1:0]  max_payload    = PAYLOAD_RESET;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [BYTE_W-1:0]   nal_byte       = '0;
    logic                first_of_unit  = 1'b0;
    logic [LENGTH_W-1:0] unit_length    = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                packet_start;
    logic                packet_end;
    logic                rtp_marker;
    logic                run_last;

    int mismatch_count;
    int pending_count;
    int bytes_taken;
    int payload_checked;

    int items_sent;
    int burst_left;
    int limit_writes;
    int idle_cycles = 0;
    int stall_span;
    int stall_mode;

    always #4 clk = ~clk;

    h264_rtp_fu_a_packetizer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_payload_we (max_payload_we),
        .max_payload    (max_payload),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .nal_byte       (nal_byte),
        .first_of_unit  (first_of_unit),
        .unit_length    (unit_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .packet_start   (packet_start),
        .packet_end     (packet_end),
        .rtp_marker     (rtp_marker),
        .run_last       (run_last)
    );

    fu_a_payload_checker u_payload_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (max_payload_we),
        .cfg_limit       (max_payload),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .nal_byte        (nal_byte),
        .first_of_unit   (first_of_unit),
        .unit_length     (unit_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .packet_start    (packet_start),
        .packet_end      (packet_end),
        .rtp_marker      (rtp_marker),
        .run_last        (run_last),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .bytes_taken     (bytes_taken),
        .payload_checked (payload_checked)
    );

    // Receiver stall: switch between quiet, light, heavy and periodic spans
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_span <= 0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_mode <= int'($urandom_range(0, 3));
                stall_span <= int'($urandom_range(20, 120));
            end
            else
            begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 6);
                default: out_stall <= (stall_span % 3 == 0);
            endcase
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Issue one request; hold it until taken, with random gaps between bursts
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first,
                             input logic [LENGTH_W-1:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = int'($urandom_range(0, 6));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = int'($urandom_range(1, 16));
        end
        burst_left--;
        in_valid      <= 1'b1;
        nal_byte      <= b;
        first_of_unit <= first;
        unit_length   <= len;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Drain all results, then write the payload limit while idle
    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (4) @(posedge clk);
        max_payload_we <= 1'b1;
        max_payload    <= v;
        @(posedge clk);
        max_payload_we <= 1'b0;
        limit_writes++;
    endtask

    // Send body bytes with random noise on the ignored length field
    task automatic send_body(input int count);
        for (int i = 0; i < count; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, LENGTH_W'($urandom));
    endtask

    // One NAL unit: mostly well formed, some abandoned, oversize or trailed by strays
    task automatic send_unit(input int lim_eff);
        int kind;
        int len;
        int span;
        kind = int'($urandom_range(0, 99));
        span = (lim_eff <= 8) ? 4 * lim_eff + 2 : 16;
        if (kind < 70)
        begin
            len = int'($urandom_range(1, span));
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, LENGTH_W'(len));
            send_body(len - 1);
        end
        else if (kind < 80)
        begin
            len = (lim_eff <= 8) ? lim_eff + int'($urandom_range(0, 1))
                                 : int'($urandom_range(1, span));
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, LENGTH_W'(len));
            send_body(len - 1);
        end
        else if (kind < 88)
        begin
            // random 24-bit length, abandoned after a few bytes
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, LENGTH_W'($urandom));
            send_body(int'($urandom_range(0, 3)));
        end
        else if (kind < 94)
        begin
            len = int'($urandom_range(2, span + 1));
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, LENGTH_W'(len));
            send_body(int'($urandom_range(0, len - 2)));
        end
        else
        begin
            len = int'($urandom_range(1, span));
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, LENGTH_W'(len));
            send_body(len - 1 + int'($urandom_range(1, 2)));
        end
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] pick;
        int                 lim_eff;
        int                 phase_end;
        items_sent   = 0;
        burst_left   = 0;
        limit_writes = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header-only unit, stray byte with no open unit, zero length
        send_byte(8'hFF, 1'b1, 24'd1);
        send_byte(8'h00, 1'b0, 24'hFFFFFF);
        send_byte(8'h00, 1'b1, 24'd0);
        // short single packet at the reset limit
        send_byte(8'h65, 1'b1, 24'd3);
        send_byte(8'h00, 1'b0, 24'd0);
        send_byte(8'hFF, 1'b0, 24'd0);
        // fragments of two with a final fragment of one
        set_limit(11'd2);
        send_byte(8'hBC, 1'b1, 24'd6);
        send_body(5);
        // limit of zero acts as one
        set_limit(11'd0);
        send_byte(8'h41, 1'b1, 24'd3);
        send_body(2);
        // limit change in the middle of a unit, then abandon it with an oversize unit
        set_limit(11'd3);
        send_byte(8'h7F, 1'b1, 24'd10);
        send_body(2);
        set_limit(11'd1);
        send_body(2);
        send_byte(8'h1F, 1'b1, 24'hFFFFFF);
        send_body(1);
        // limit above the ceiling clamps to 1498
        set_limit(11'h7FF);
        send_byte(8'h05, 1'b1, 24'd1500);
        send_body(1);
        send_byte(8'hE6, 1'b1, 24'd1498);
        send_body(1);

        // random phases, each under its own limit
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       pick = 11'd0;
                1:       pick = 11'd1;
                2:       pick = 11'd2;
                3:       pick = 11'd3;
                4:       pick = LIMIT_W'($urandom_range(4, 8));
                5:       pick = PAYLOAD_CEILING;
                6:       pick = 11'h7FF;
                default: pick = LIMIT_W'($urandom_range(0, 2047));
            endcase
            lim_eff = (pick == '0) ? 1
                    : (pick > PAYLOAD_CEILING) ? int'(PAYLOAD_CEILING) : int'(pick);
            set_limit(pick);
            phase_end = items_sent + 32;
            while (items_sent < phase_end && items_sent < RANDOM_ITEMS)
                send_unit(lim_eff);
        end

        // drain, then allow the pipeline to settle
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (8) @(posedge clk);

        $display("Run covered %0d NAL bytes and %0d payload bytes under %0d limit settings.",
                 bytes_taken, payload_checked, limit_writes + 1);
        $display("Included clamped limits, zero and oversize lengths, abandoned units and strays.");
        if (pending_count != 0)
            $display("ERROR: %0d predicted payload bytes never arrived", pending_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/h264fu_pkg.sv
sv/h264_rtp_fu_a_packetizer_top.sv
dv/fu_a_payload_checker.sv
dv/h264_rtp_fu_a_packetizer_top_tb.sv
